// ===== sv/cgtr_pkg.sv =====
// Shared types, constants and saturation helper for the trust region step core.
package cgtr_pkg;

  localparam int MaxDim    = 16;
  localparam int IdxBits   = 4;
  localparam int DimBits   = 5;
  localparam int ValBits   = 32;
  localparam int AccBits   = 64;
  localparam int RadBits   = 31;
  localparam int CfgAw     = 2;
  localparam int TdInBits  = 72;
  localparam int TdOutBits = 40;
  localparam int BitTop    = 30;

  localparam logic [1:0] OP_LOAD_GRAD = 2'd0;
  localparam logic [1:0] OP_LOAD_HESS = 2'd1;
  localparam logic [1:0] OP_SOLVE     = 2'd2;

  localparam logic [CfgAw-1:0] REG_DIM = '0;
  localparam logic [DimBits-1:0] DIM_RESET = 5'd16;

  localparam logic signed [ValBits-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [ValBits-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [16:0] {
    S_IDLE     = 17'b1 << 0,
    S_RAD2     = 17'b1 << 1,
    S_INIT     = 17'b1 << 2,
    S_MATVEC   = 17'b1 << 3,
    S_DHD      = 17'b1 << 4,
    S_RR       = 17'b1 << 5,
    S_DIV_GO   = 17'b1 << 6,
    S_DIV_WAIT = 17'b1 << 7,
    S_PNEW     = 17'b1 << 8,
    S_PNORM    = 17'b1 << 9,
    S_RNEW     = 17'b1 << 10,
    S_RNORM    = 17'b1 << 11,
    S_COPYP    = 17'b1 << 12,
    S_UPD      = 17'b1 << 13,
    S_BND      = 17'b1 << 14,
    S_FINAL    = 17'b1 << 15,
    S_OUT      = 17'b1 << 16
  } state_t;

  // Clamp a wide signed value into the signed element range.
  function automatic logic signed [ValBits-1:0] sat32(input logic signed [AccBits-1:0] x);
    logic signed [ValBits-1:0] res;
    if (x > AccBits'(VAL_MAX)) begin
      res = VAL_MAX;
    end else if (x < AccBits'(VAL_MIN)) begin
      res = VAL_MIN;
    end else begin
      res = x[ValBits-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/cgtr_div.sv =====
// Restoring divider giving floor(num * 2^16 / den), saturated to the positive element range.
module cgtr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cgtr_pkg::AccBits-1:0] num,
  input  logic [cgtr_pkg::AccBits-1:0] den,
  output logic                         done,
  output logic [cgtr_pkg::ValBits-1:0] quot
);
  import cgtr_pkg::*;

  logic                   busy_r;
  logic [4:0]             cnt_r;
  logic [AccBits-1:0]     rem_r;
  logic [AccBits-1:0]     den_r;
  logic [30:0]            nlo_r;
  logic [30:0]            q_r;
  logic                   done_r;
  logic [ValBits-1:0]     res_r;
  logic [AccBits:0]       trial_w;
  logic                   ge_w;
  logic [30:0]            qn_w;

  // One quotient bit per cycle: shift in the next numerator bit and try a subtract.
  assign trial_w = {rem_r, nlo_r[30]};
  assign ge_w    = trial_w >= {1'b0, den_r};
  assign qn_w    = {q_r[29:0], ge_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        if (num == '0 || den == '0) begin
          res_r  <= '0;
          done_r <= 1'b1;
        end else if ({15'b0, num} >= {den, 15'b0}) begin
          res_r  <= VAL_MAX;
          done_r <= 1'b1;
        end else begin
          rem_r  <= {15'b0, num[AccBits-1:15]};
          nlo_r  <= {num[14:0], 16'b0};
          q_r    <= '0;
          cnt_r  <= 5'd31;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge_w ? AccBits'(trial_w - {1'b0, den_r}) : trial_w[AccBits-1:0];
        nlo_r <= {nlo_r[29:0], 1'b0};
        q_r   <= qn_w;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= {1'b0, qn_w};
        end
      end
    end
  end

  assign done = done_r;
  assign quot = res_r;

endmodule

// ===== sv/cg_trust_region_step_core.sv =====
// Top level of the truncated conjugate gradient trust region step core.
//
// Usage: the input stream carries one transaction per cycle while the core is
// idle. tuser holds the operation: load a gradient element, load a Hessian
// element, or start a solve. Loads produce nothing. A start transaction runs
// Steihaug conjugate gradient on the loaded data with the given radius and
// then emits dim_in_use step elements on the output stream, tlast on the last.
// All arithmetic goes through one shared 32x32 multiplier and adder driven by
// a sequencer, plus a bit-serial divider for alpha and beta; each divide holds
// the sequencer in its divide states until the quotient is ready. in_tready is
// high only while idle. The output register holds an element until the
// receiver takes it; a stall simply holds the sequencer in its emit state.
// Reset (rst_n low, synchronous) returns to idle, clears the output valid and
// sets dim_in_use to 16; the stores keep whatever they held and must be
// loaded before a solve.
module cg_trust_region_step_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // row[3:0], col[7:4], value[39:8], radius[70:40], zero[71]
  input  logic [cgtr_pkg::TdInBits-1:0]   in_tdata,
  // operation[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // index[3:0], step_value[35:4], zero[39:36]
  output logic [cgtr_pkg::TdOutBits-1:0]  out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cgtr_pkg::CfgAw-1:0]      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import cgtr_pkg::*;

  state_t state_r, state_nxt;

  logic [DimBits-1:0]         dim_r;
  logic [DimBits-1:0]         n_w;
  logic [IdxBits-1:0]         nm1_w;
  logic [IdxBits-1:0]         i_r, j_r, vi_w;
  logic [DimBits-1:0]         k_r;
  logic [4:0]                 b_r;
  logic                       ph_r;
  logic                       zero_r;
  logic                       beta_sel_r;
  logic                       last_i_w, last_j_w;

  logic [RadBits-1:0]         rad_r;
  logic signed [AccBits-1:0]  rad2_r, dhd_r, rr_r, rp2_r, acc_r;
  logic signed [ValBits-1:0]  sc_r, v_r, cand_w;

  logic signed [ValBits-1:0]  g_mem [MaxDim];
  logic signed [ValBits-1:0]  p_mem [MaxDim];
  logic signed [ValBits-1:0]  r_mem [MaxDim];
  logic signed [ValBits-1:0]  d_mem [MaxDim];
  logic signed [ValBits-1:0]  c_mem [MaxDim];
  logic signed [ValBits-1:0]  pn_mem[MaxDim];
  logic signed [ValBits-1:0]  rn_mem[MaxDim];
  logic [ValBits-1:0]         h_mem [MaxDim*MaxDim];
  logic signed [ValBits-1:0]  h_q_r;

  logic signed [ValBits-1:0]  g_w, p_w, r_w, d_w, c_w, pn_w, rn_w;
  logic signed [ValBits-1:0]  ma_w, mb_w;
  logic signed [AccBits-1:0]  prod_w, q_w, addend_w, sum_w;
  logic signed [ValBits-1:0]  sat_w;

  logic                       in_acc_w;
  logic [1:0]                 op_w;
  logic [IdxBits-1:0]         row_w, col_w;
  logic signed [ValBits-1:0]  val_w;
  logic [RadBits-1:0]         radius_w;

  logic                       div_start_w, div_done_w;
  logic [AccBits-1:0]         div_num_w, div_den_w;
  logic [ValBits-1:0]         div_q_w;

  logic                       ov_r;
  logic [IdxBits-1:0]         oidx_r;
  logic signed [ValBits-1:0]  oval_r;
  logic                       olast_r;
  logic                       emit_w;

  // Input field unpacking.
  assign op_w     = in_tuser;
  assign row_w    = in_tdata[3:0];
  assign col_w    = in_tdata[7:4];
  assign val_w    = in_tdata[39:8];
  assign radius_w = in_tdata[70:40];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc_w  = in_tvalid && in_tready;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_DIM) ? {27'b0, dim_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_DIM) begin
      dim_r <= cfg_pwdata[DimBits-1:0];
    end
  end

  // Vector length in use, clamped to the supported range.
  assign n_w = (dim_r == '0) ? 5'd1 : ((dim_r > 5'(MaxDim)) ? 5'(MaxDim) : dim_r);
  assign nm1_w    = IdxBits'(n_w - 5'd1);
  assign last_i_w = (i_r == nm1_w);
  assign last_j_w = (j_r == nm1_w);

  // Vector reads share one index: the column during the matrix product, else the row.
  assign vi_w = (state_r == S_MATVEC) ? j_r : i_r;
  assign g_w  = g_mem[vi_w];
  assign p_w  = p_mem[vi_w];
  assign r_w  = r_mem[vi_w];
  assign d_w  = d_mem[vi_w];
  assign c_w  = c_mem[vi_w];
  assign pn_w = pn_mem[vi_w];
  assign rn_w = rn_mem[vi_w];

  assign cand_w = sc_r | (ValBits'(1) << b_r);

  // Shared multiplier operand and addend selection.
  always_comb begin
    ma_w     = p_w;
    mb_w     = p_w;
    addend_w = acc_r;
    unique case (state_r)
      S_RAD2:   begin ma_w = {1'b0, rad_r}; mb_w = {1'b0, rad_r}; end
      S_MATVEC: begin ma_w = h_q_r; mb_w = d_w; end
      S_DHD:    begin ma_w = d_w;   mb_w = c_w; end
      S_RR:     begin ma_w = r_w;   mb_w = r_w; end
      S_PNEW:   begin ma_w = sc_r;  mb_w = d_w; addend_w = AccBits'(p_w); end
      S_PNORM:  begin ma_w = pn_w;  mb_w = pn_w; end
      S_RNEW:   begin ma_w = sc_r;  mb_w = c_w; addend_w = AccBits'(r_w); end
      S_RNORM:  begin ma_w = rn_w;  mb_w = rn_w; end
      S_UPD:    begin ma_w = sc_r;  mb_w = d_w; addend_w = -AccBits'(rn_w); end
      S_BND: begin
        if (!ph_r) begin
          ma_w = cand_w; mb_w = d_w; addend_w = AccBits'(p_w);
        end else begin
          ma_w = v_r; mb_w = v_r;
        end
      end
      S_FINAL:  begin ma_w = sc_r;  mb_w = d_w; addend_w = AccBits'(p_w); end
      default:  begin ma_w = p_w;   mb_w = p_w; end
    endcase
  end

  assign prod_w = ma_w * mb_w;
  assign q_w    = prod_w >>> 16;
  assign sum_w  = addend_w + q_w;
  assign sat_w  = sat32(sum_w);

  // Divider operands: alpha = rr/dHd, beta = rr'/rr.
  assign div_start_w = (state_r == S_DIV_GO);
  assign div_num_w   = beta_sel_r ? rp2_r : rr_r;
  assign div_den_w   = beta_sel_r ? rr_r  : dhd_r;

  cgtr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_w),
    .num   (div_num_w),
    .den   (div_den_w),
    .done  (div_done_w),
    .quot  (div_q_w)
  );

  assign emit_w = (state_r == S_OUT) && (!ov_r || out_tready);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_acc_w && op_w == OP_SOLVE) state_nxt = S_RAD2;
      S_RAD2:     state_nxt = S_INIT;
      S_INIT: begin
        if (last_i_w) state_nxt = (zero_r && g_w == '0) ? S_OUT : S_MATVEC;
      end
      S_MATVEC:   if (ph_r && last_j_w && last_i_w) state_nxt = S_DHD;
      S_DHD:      if (last_i_w) state_nxt = (sum_w <= 0) ? S_BND : S_RR;
      S_RR:       if (last_i_w) state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done_w) state_nxt = beta_sel_r ? S_UPD : S_PNEW;
      S_PNEW:     if (last_i_w) state_nxt = S_PNORM;
      S_PNORM:    if (last_i_w) state_nxt = (sum_w >= rad2_r) ? S_BND : S_RNEW;
      S_RNEW:     if (last_i_w) state_nxt = S_RNORM;
      S_RNORM:    if (last_i_w) state_nxt = (sum_w == 0) ? S_COPYP : S_DIV_GO;
      S_COPYP:    if (last_i_w) state_nxt = S_OUT;
      S_UPD: begin
        if (last_i_w) state_nxt = (k_r + 5'd1 == n_w) ? S_OUT : S_MATVEC;
      end
      S_BND:      if (ph_r && last_i_w && b_r == '0) state_nxt = S_FINAL;
      S_FINAL:    if (last_i_w) state_nxt = S_OUT;
      S_OUT:      if (emit_w && last_i_w) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Control registers: state, counters and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      b_r        <= '0;
      ph_r       <= 1'b0;
      zero_r     <= 1'b1;
      beta_sel_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tready && !emit_w) ov_r <= 1'b0;
      unique case (state_r)
        S_RAD2: begin
          i_r    <= '0;
          zero_r <= 1'b1;
        end
        S_INIT: begin
          if (g_w != '0) zero_r <= 1'b0;
          if (last_i_w) begin
            i_r  <= '0;
            j_r  <= '0;
            k_r  <= '0;
            ph_r <= 1'b0;
          end else begin
            i_r <= i_r + 4'd1;
          end
        end
        S_MATVEC: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            if (last_j_w) begin
              j_r <= '0;
              i_r <= last_i_w ? '0 : i_r + 4'd1;
            end else begin
              j_r <= j_r + 4'd1;
            end
          end
        end
        S_DHD, S_RR, S_PNEW, S_PNORM, S_RNEW, S_RNORM, S_COPYP, S_FINAL: begin
          i_r <= last_i_w ? '0 : i_r + 4'd1;
          if (state_r == S_DHD && last_i_w) begin
            b_r  <= 5'(BitTop);
            ph_r <= 1'b0;
          end
          if (state_r == S_RR) beta_sel_r <= 1'b0;
          if (state_r == S_RNORM) beta_sel_r <= 1'b1;
          if (state_r == S_PNORM && last_i_w) begin
            b_r  <= 5'(BitTop);
            ph_r <= 1'b0;
          end
        end
        S_UPD: begin
          if (last_i_w) begin
            i_r  <= '0;
            j_r  <= '0;
            ph_r <= 1'b0;
            k_r  <= k_r + 5'd1;
          end else begin
            i_r <= i_r + 4'd1;
          end
        end
        S_BND: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            if (last_i_w) begin
              i_r <= '0;
              if (b_r != '0) b_r <= b_r - 5'd1;
            end else begin
              i_r <= i_r + 4'd1;
            end
          end
        end
        S_DIV_WAIT: i_r <= '0;
        S_OUT: begin
          if (emit_w) begin
            ov_r <= 1'b1;
            i_r  <= last_i_w ? '0 : i_r + 4'd1;
          end
        end
        default: begin
          i_r <= '0;
        end
      endcase
    end
  end

  // Datapath registers and vector stores.
  always_ff @(posedge clk) begin
    h_q_r <= h_mem[{i_r, j_r}];
    if (in_acc_w && op_w == OP_LOAD_HESS) h_mem[{row_w, col_w}] <= val_w;
    if (in_acc_w && op_w == OP_LOAD_GRAD) g_mem[row_w] <= val_w;
    if (in_acc_w && op_w == OP_SOLVE) rad_r <= radius_w;
    case (state_r)
      S_RAD2: rad2_r <= q_w;
      S_INIT: begin
        p_mem[i_r] <= '0;
        r_mem[i_r] <= g_w;
        d_mem[i_r] <= sat32(-AccBits'(g_w));
        acc_r      <= '0;
      end
      S_MATVEC: begin
        if (ph_r) begin
          if (last_j_w) begin
            c_mem[i_r] <= sat_w;
            acc_r      <= '0;
          end else begin
            acc_r <= sum_w;
          end
        end
      end
      S_DHD, S_RR, S_PNORM, S_RNORM: begin
        acc_r <= last_i_w ? '0 : sum_w;
        if (last_i_w) begin
          if (state_r == S_DHD) dhd_r <= sum_w;
          if (state_r == S_RR) rr_r <= sum_w;
          if (state_r == S_RNORM) rp2_r <= sum_w;
          if (state_r == S_DHD) sc_r <= '0;
          // Alpha stays in place for the residual update unless the step leaves the radius.
          if (state_r == S_PNORM && sum_w >= rad2_r) sc_r <= '0;
        end
      end
      S_DIV_WAIT: if (div_done_w) sc_r <= div_q_w;
      S_PNEW:  pn_mem[i_r] <= sat_w;
      S_RNEW:  rn_mem[i_r] <= sat_w;
      S_COPYP: p_mem[i_r] <= pn_w;
      S_UPD: begin
        d_mem[i_r] <= sat_w;
        r_mem[i_r] <= rn_w;
        p_mem[i_r] <= pn_w;
      end
      S_BND: begin
        if (!ph_r) begin
          v_r <= sat_w;
        end else if (last_i_w) begin
          acc_r <= '0;
          if (sum_w <= rad2_r) sc_r <= cand_w;
        end else begin
          acc_r <= sum_w;
        end
      end
      S_FINAL: p_mem[i_r] <= sat_w;
      S_OUT: begin
        if (emit_w) begin
          oidx_r  <= i_r;
          oval_r  <= p_w;
          olast_r <= last_i_w;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'b0, oval_r, oidx_r};
  assign out_tlast  = olast_r;

endmodule

// ===== verif/cg_trust_region_step_core_tb.sv =====
// Self-checking testbench for the trust region conjugate gradient step core.
module cg_trust_region_step_core_tb;
  import cgtr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;
  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [IdxBits-1:0] index;
    logic [ValBits-1:0] step_value;
    logic               last;
  } step_elem_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [TdInBits-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [TdOutBits-1:0] out_tdata;
  logic out_tlast;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CfgAw-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Predictor state: stores, working vectors and the dimension register.
  longint grad_mem [MaxDim];
  longint hess_mem [MaxDim][MaxDim];
  longint step_v [MaxDim];
  longint resid_v [MaxDim];
  longint dir_v [MaxDim];
  longint curv_v [MaxDim];
  logic [DimBits-1:0] dim_reg;

  step_elem_t step_q[$];
  int err_cnt;
  int cycle_cnt;
  int burst_left;
  bit held_valid;

  cg_trust_region_step_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate to the signed 32-bit element range.
  function automatic longint qsat(longint x);
    if (x > SatHi) return SatHi;
    if (x < SatLo) return SatLo;
    return x;
  endfunction

  // Q16.16 product, floored.
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  // Floored Q16.16 quotient for a nonnegative numerator and positive divisor.
  function automatic longint qdiv(longint num, longint den);
    longint unsigned un, ud, q, rem, frac;
    if (num <= 0 || den <= 0) return 0;
    un = num;
    ud = den;
    q = un / ud;
    rem = un % ud;
    frac = 0;
    if (q > (longint'(SatHi) >> 16)) return SatHi;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= ud) begin
        rem = rem - ud;
        frac = frac | 1;
      end
    end
    return qsat(longint'((q << 16) | frac));
  endfunction

  function automatic longint vec_dot(longint a[MaxDim], longint b[MaxDim], int n);
    longint s;
    s = 0;
    for (int i = 0; i < n; i++) s += qmul(a[i], b[i]);
    return s;
  endfunction

  // Whether the square norm of the step moved by t along the direction fits the squared radius.
  function automatic bit fits_radius(longint t, int n, longint rad2);
    longint s, v;
    s = 0;
    for (int i = 0; i < n; i++) begin
      v = qsat(step_v[i] + qmul(t, dir_v[i]));
      s += qmul(v, v);
    end
    return s <= rad2;
  endfunction

  // Bit search for the largest boundary factor, then move the step there.
  function automatic void move_to_boundary(int n, longint rad2);
    longint t, cand;
    t = 0;
    for (int b = 30; b >= 0; b--) begin
      cand = t | (longint'(1) << b);
      if (fits_radius(cand, n, rad2)) t = cand;
    end
    for (int i = 0; i < n; i++) step_v[i] = qsat(step_v[i] + qmul(t, dir_v[i]));
  endfunction

  // Truncated conjugate gradient on the stored problem; queues the step.
  function automatic void predict_step(logic [RadBits-1:0] radius);
    longint rad2, dhd, rr, rp2, alpha, beta, s;
    longint pnew [MaxDim];
    longint rnew [MaxDim];
    int n, k;
    bit all_zero;
    step_elem_t e;
    n = (dim_reg == 0) ? 1 : ((dim_reg > MaxDim) ? MaxDim : int'(dim_reg));
    rad2 = (longint'(radius) * longint'(radius)) >> 16;
    k = 0;
    all_zero = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (grad_mem[i] != 0) all_zero = 1'b0;
      step_v[i] = 0;
      resid_v[i] = grad_mem[i];
      dir_v[i] = qsat(-grad_mem[i]);
    end
    while (!all_zero && k < n) begin
      for (int i = 0; i < n; i++) begin
        s = 0;
        for (int j = 0; j < n; j++) s += qmul(hess_mem[i][j], dir_v[j]);
        curv_v[i] = qsat(s);
      end
      dhd = vec_dot(dir_v, curv_v, n);
      if (dhd <= 0) begin
        move_to_boundary(n, rad2);
        break;
      end
      rr = vec_dot(resid_v, resid_v, n);
      alpha = qdiv(rr, dhd);
      for (int i = 0; i < n; i++) pnew[i] = qsat(step_v[i] + qmul(alpha, dir_v[i]));
      if (vec_dot(pnew, pnew, n) >= rad2) begin
        move_to_boundary(n, rad2);
        break;
      end
      for (int i = 0; i < n; i++) rnew[i] = qsat(resid_v[i] + qmul(alpha, curv_v[i]));
      rp2 = vec_dot(rnew, rnew, n);
      if (rp2 == 0) begin
        for (int i = 0; i < n; i++) step_v[i] = pnew[i];
        break;
      end
      beta = (rr == 0) ? 0 : qdiv(rp2, rr);
      for (int i = 0; i < n; i++) begin
        dir_v[i] = qsat(-rnew[i] + qmul(beta, dir_v[i]));
        resid_v[i] = rnew[i];
        step_v[i] = pnew[i];
      end
      k++;
    end
    for (int i = 0; i < n; i++) begin
      e.index = IdxBits'(i);
      e.step_value = step_v[i][31:0];
      e.last = (i == n - 1);
      step_q.push_back(e);
    end
  endfunction

  // Send one transaction; the sender keeps valid high within a burst.
  task automatic send_item(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                           logic [31:0] value, logic [RadBits-1:0] radius);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, radius, value, col, row};
    do @(posedge clk); while (!in_tready);
    case (op)
      OP_LOAD_GRAD: grad_mem[row] = longint'($signed(value));
      OP_LOAD_HESS: hess_mem[row][col] = longint'($signed(value));
      OP_SOLVE: predict_step(radius);
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
      held_valid = 1'b1;
    end else begin
      in_tvalid <= 1'b0;
      held_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // Stop sending and wait until every expected step element has arrived.
  task automatic wait_idle();
    if (held_valid) begin
      in_tvalid <= 1'b0;
      held_valid = 1'b0;
      @(posedge clk);
    end
    while (step_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write: a setup phase, then an access phase.
  task automatic write_dim(logic [DimBits-1:0] value);
    wait_idle();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_DIM;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    dim_reg = value;
  endtask

  function automatic logic [31:0] rand_small(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Every store entry gets written once so no solve reads an unloaded entry.
  task automatic test_fill();
    for (int i = 0; i < MaxDim; i++) send_item(OP_LOAD_GRAD, 4'(i), 4'd0, rand_small(1 << 18), '0);
    for (int i = 0; i < MaxDim; i++) begin
      for (int j = 0; j < MaxDim; j++) begin
        if (i == j) send_item(OP_LOAD_HESS, 4'(i), 4'(j), 32'($urandom_range(1 << 17, 1 << 19)), '0);
        else send_item(OP_LOAD_HESS, 4'(i), 4'(j), rand_small(1 << 13), '0);
      end
    end
  endtask

  // One-variable problems that hit most exits of the solver.
  task automatic test_exits();
    write_dim(5'd1);
    // Exact solution inside the radius: the residual vanishes.
    send_item(OP_LOAD_GRAD, 4'd0, 4'd0, 32'h0001_0000, '0);
    send_item(OP_LOAD_HESS, 4'd0, 4'd0, 32'h0001_0000, '0);
    send_item(OP_SOLVE, 4'd0, 4'd0, '0, 31'h0064_0000);
    // The same problem with the step cut off at the boundary.
    send_item(OP_SOLVE, 4'd0, 4'd0, '0, 31'h0000_8000);
    // Negative curvature.
    send_item(OP_LOAD_HESS, 4'd0, 4'd0, 32'hFFFF_0000, '0);
    send_item(OP_SOLVE, 4'd0, 4'd0, '0, 31'h0002_0000);
    // Tiny residual that rounds away.
    send_item(OP_LOAD_HESS, 4'd0, 4'd0, 32'h0001_0000, '0);
    send_item(OP_LOAD_GRAD, 4'd0, 4'd0, 32'h0000_0001, '0);
    send_item(OP_SOLVE, 4'd0, 4'd0, '0, 31'h0001_0000);
    // Zero gradient.
    send_item(OP_LOAD_GRAD, 4'd0, 4'd0, 32'h0, '0);
    send_item(OP_SOLVE, 4'd0, 4'd0, '0, 31'h0001_0000);
    // Unused operation is ignored.
    send_item(OP_UNUSED, 4'hF, 4'hF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
  endtask

  // Field extremes: saturating values, zero and full radius, top indexes.
  task automatic test_extremes();
    send_item(OP_LOAD_GRAD, 4'd0, 4'd0, 32'h8000_0000, '0);
    send_item(OP_LOAD_HESS, 4'd0, 4'd0, 32'h7FFF_FFFF, '0);
    send_item(OP_SOLVE, 4'd0, 4'd0, '0, 31'h7FFF_FFFF);
    send_item(OP_LOAD_GRAD, 4'd0, 4'd0, 32'h7FFF_FFFF, '0);
    send_item(OP_SOLVE, 4'd0, 4'd0, '0, '0);
    send_item(OP_LOAD_HESS, 4'hF, 4'hF, 32'h8000_0000, '0);
    send_item(OP_LOAD_GRAD, 4'hF, 4'd0, 32'h0003_0000, '0);
    write_dim(5'd16);
    send_item(OP_SOLVE, 4'd0, 4'd0, '0, 31'h7FFF_FFFF);
    // Restore a tame last row and column entry for later problems.
    send_item(OP_LOAD_HESS, 4'hF, 4'hF, 32'h0004_0000, '0);
  endtask

  // Random problems: mostly well-formed load sequences followed by a solve.
  task automatic test_random(logic [DimBits-1:0] dim, int items);
    int n, sent, kind, r, c;
    logic [31:0] v;
    write_dim(dim);
    n = (dim == 0) ? 1 : ((dim > MaxDim) ? MaxDim : int'(dim));
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        for (int i = 0; i < n; i++) begin
          v = ($urandom_range(0, 12) == 0) ? 32'h0 : rand_small(1 << 18);
          send_item(OP_LOAD_GRAD, 4'(i), 4'(i), v, '0);
        end
        for (int i = 0; i < n; i++) begin
          v = ($urandom_range(0, 7) == 0) ? rand_small(1 << 18)
                                          : 32'($urandom_range(1 << 16, 1 << 19));
          send_item(OP_LOAD_HESS, 4'(i), 4'(i), v, '0);
        end
        repeat ($urandom_range(0, 3)) begin
          r = $urandom_range(0, n - 1);
          c = $urandom_range(0, n - 1);
          v = rand_small(1 << 14);
          send_item(OP_LOAD_HESS, 4'(r), 4'(c), v, '0);
          send_item(OP_LOAD_HESS, 4'(c), 4'(r), v, '0);
        end
        send_item(OP_SOLVE, 4'($urandom), 4'($urandom), $urandom,
                  ($urandom_range(0, 5) == 0) ? RadBits'($urandom)
                                              : RadBits'($urandom_range(1 << 10, 1 << 20)));
        sent += 2 * n + 1;
      end else begin
        // Noise: any operation with any field values.
        send_item(2'($urandom), 4'($urandom), 4'($urandom), $urandom, RadBits'($urandom));
        sent++;
      end
      // Now and then let everything drain before sending more.
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
  endtask

  // Result checking and the receiver's stall pattern.
  int stall_mode;
  int mode_left;
  always @(posedge clk) begin
    step_elem_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (step_q.size() == 0) begin
        $error("unexpected step element, index %0d", out_tdata[3:0]);
        err_cnt++;
      end else begin
        e = step_q.pop_front();
        if (out_tdata[3:0] !== e.index) begin
          $error("index: expected %0d, actual %0d", e.index, out_tdata[3:0]);
          err_cnt++;
        end
        if (out_tdata[35:4] !== e.step_value) begin
          $error("step_value: expected %h, actual %h", e.step_value, out_tdata[35:4]);
          err_cnt++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, out_tlast);
          err_cnt++;
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    err_cnt = 0;
    cycle_cnt = 0;
    burst_left = 0;
    held_valid = 1'b0;
    stall_mode = 0;
    mode_left = 0;
    dim_reg = DIM_RESET;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_LOAD_GRAD;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill();
    test_exits();
    test_extremes();
    test_random(5'd4, 10);
    test_random(5'd1, 5);
    test_random(5'd0, 3);
    test_random(5'd15, 1);
    test_random(5'd31, 1);
    test_random(5'd9, 4);
    wait_idle();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
